[src/pgh_pkg.sv]
`timescale 1ns / 1ps

package pgh_pkg;

  // trace and score sizing
  localparam int TRACE_SLOTS = 8;
  localparam int CODE_BITS   = 16;
  localparam int WEIGHT_BITS = 3;
  localparam int SCORE_BITS  = 8;

  // histogram sizing
  localparam int BIN_COUNT   = 31;
  localparam int BIN_BITS    = 5;
  localparam int COUNT_BITS  = 32;
  localparam int ADDR_BITS   = BIN_BITS + 1;
  localparam int BIN_DEPTH   = 2 ** ADDR_BITS;

  // configuration registers
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = 3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_READ_WEIGHT  = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_WRITE_WEIGHT = 1'd1;
  localparam logic [WEIGHT_BITS-1:0]   READ_WEIGHT_RST  = 3'd1;
  localparam logic [WEIGHT_BITS-1:0]   WRITE_WEIGHT_RST = 3'd3;

  // access codes in the trace
  localparam logic [1:0] CODE_READ  = 2'd1;
  localparam logic [1:0] CODE_WRITE = 2'd2;

  // stream word widths
  localparam int IN_DATA_BITS  = 24;
  localparam int OUT_DATA_BITS = 112;

  // score unit result
  typedef struct packed {
    logic [SCORE_BITS-1:0] score;
    logic [BIN_BITS-1:0]   bin;
    logic                  countable;
    logic                  oor;
  } pgh_score_t;

endpackage

[src/page_heat_histogram.sv]
`timescale 1ns / 1ps

// Per-tier heat histogram of tracked pages.
// Input stream: one page record per word; tlast marks the final page of a scan
// and is echoed on the output word of that page. Every input word yields
// exactly one output word carrying the score, the bin, the updated bin count
// and both tier totals.
// Configuration: read and write weights are written through cfg_wr_en,
// cfg_addr and cfg_wdata; the user must do so only while no word is in flight;
// the block does not enforce this. Throughput: one page per cycle unless
// stalled. The bin counts sit in one 64-entry memory (two tiers of 31 bins)
// with a registered read; the read-modify-write is split between that read
// and the second stage, and a forwarding register bypasses the latest write.
// Reset: weights return to 1 and 3, totals clear and a per-entry valid flag
// makes every bin read as zero at once, so words are taken right after reset.
// Stall: a held output word keeps the second stage, and the input side stops
// taking words only while that stage is full and the output word is held.
module page_heat_histogram (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [pgh_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [pgh_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  // page records
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // page_present, split_page, split_hot, in_dram, access_codes[15:0], zero pad
  input  logic [pgh_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  input  logic                                s_axis_tlast,
  // results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // score[7:0], bin_index[4:0], counted, out_of_range, bin_count[31:0],
  // dram_total[31:0], nvm_total[31:0], zero pad
  output logic [pgh_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  output logic                                m_axis_tlast
);
  import pgh_pkg::*;

  // configuration
  logic [WEIGHT_BITS-1:0] read_weight;
  logic [WEIGHT_BITS-1:0] write_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_weight  <= READ_WEIGHT_RST;
      write_weight <= WRITE_WEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_READ_WEIGHT:  read_weight  <= cfg_wdata[WEIGHT_BITS-1:0];
        REG_WRITE_WEIGHT: write_weight <= cfg_wdata[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input word fields
  logic                 in_present;
  logic                 in_split;
  logic                 in_hot;
  logic                 in_dram;
  logic [CODE_BITS-1:0] in_codes;

  assign in_present = s_axis_tdata[0];
  assign in_split   = s_axis_tdata[1];
  assign in_hot     = s_axis_tdata[2];
  assign in_dram    = s_axis_tdata[3];
  assign in_codes   = s_axis_tdata[4 +: CODE_BITS];

  pgh_score_t in_res;

  pgh_score u_score (
    .read_weight  (read_weight),
    .write_weight (write_weight),
    .page_present (in_present),
    .split_page   (in_split),
    .split_hot    (in_hot),
    .access_codes (in_codes),
    .res          (in_res)
  );

  // pipeline control
  logic s1_valid;
  logic s1_move;
  logic in_accept;

  assign s1_move       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_move;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // bin memory and per-entry valid flags
  logic [COUNT_BITS-1:0] bin_mem [0:BIN_DEPTH-1];
  logic [BIN_DEPTH-1:0]  bin_valid;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  rd_valid;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  assign rd_addr = {in_dram, in_res.bin};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bin_mem[wr_addr] <= wr_data;
    end
    if (in_accept) begin
      rd_data <= bin_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
    end else if (wr_en) begin
      bin_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_valid <= bin_valid[rd_addr];
    end
  end

  // second stage registers
  pgh_score_t s1_res;
  logic       s1_dram;
  logic       s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_res  <= in_res;
      s1_dram <= in_dram;
      s1_last <= s_axis_tlast;
    end
  end

  // forward the latest write over the memory read
  logic                  fwd_valid;
  logic [ADDR_BITS-1:0]  fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;
  logic [ADDR_BITS-1:0]  s1_addr;
  logic [COUNT_BITS-1:0] old_count;
  logic [COUNT_BITS-1:0] new_count;

  assign s1_addr = {s1_dram, s1_res.bin};

  always_comb begin
    if (fwd_valid && (fwd_addr == s1_addr)) begin
      old_count = fwd_data;
    end else if (rd_valid) begin
      old_count = rd_data;
    end else begin
      old_count = '0;
    end
  end

  // saturating increment
  assign new_count = (&old_count) ? old_count : old_count + COUNT_BITS'(1);

  assign wr_en   = s1_move && s1_res.countable;
  assign wr_addr = s1_addr;
  assign wr_data = new_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= wr_addr;
      fwd_data <= wr_data;
    end
  end

  // tier totals
  logic [COUNT_BITS-1:0] dram_total;
  logic [COUNT_BITS-1:0] nvm_total;
  logic [COUNT_BITS-1:0] dram_total_next;
  logic [COUNT_BITS-1:0] nvm_total_next;

  always_comb begin
    dram_total_next = dram_total;
    nvm_total_next  = nvm_total;
    if (wr_en && s1_dram && !(&dram_total)) begin
      dram_total_next = dram_total + COUNT_BITS'(1);
    end
    if (wr_en && !s1_dram && !(&nvm_total)) begin
      nvm_total_next = nvm_total + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dram_total <= '0;
      nvm_total  <= '0;
    end else begin
      dram_total <= dram_total_next;
      nvm_total  <= nvm_total_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_axis_tdata <= {1'b0,
                       nvm_total_next,
                       dram_total_next,
                       s1_res.countable ? new_count : {COUNT_BITS{1'b0}},
                       s1_res.oor,
                       s1_res.countable,
                       s1_res.bin,
                       s1_res.score};
      m_axis_tlast <= s1_last;
    end
  end

endmodule

[src/pgh_score.sv]
`timescale 1ns / 1ps

module pgh_score (
  input  logic [pgh_pkg::WEIGHT_BITS-1:0] read_weight,
  input  logic [pgh_pkg::WEIGHT_BITS-1:0] write_weight,
  input  logic                            page_present,
  input  logic                            split_page,
  input  logic                            split_hot,
  input  logic [pgh_pkg::CODE_BITS-1:0]   access_codes,
  output pgh_pkg::pgh_score_t             res
);
  import pgh_pkg::*;

  logic [SCORE_BITS-1:0] trace_sum;
  logic [SCORE_BITS-1:0] raw_score;
  logic [CODE_BITS-1:0]  shifted;
  logic [SCORE_BITS-1:0] rd_w;
  logic [SCORE_BITS-1:0] wr_w;
  logic                  fits;

  assign rd_w = {{(SCORE_BITS-WEIGHT_BITS){1'b0}}, read_weight};
  assign wr_w = {{(SCORE_BITS-WEIGHT_BITS){1'b0}}, write_weight};

  // weighted sum over the trace slots, slots past the field read as no access
  always_comb begin
    trace_sum = '0;
    shifted   = '0;
    for (int i = 0; i < TRACE_SLOTS; i++) begin
      shifted = access_codes >> (2 * i);
      if (shifted[1:0] == CODE_READ) begin
        trace_sum = trace_sum + rd_w;
      end else if (shifted[1:0] == CODE_WRITE) begin
        trace_sum = trace_sum + wr_w;
      end
    end
  end

  // cold split page scores one
  assign raw_score = (split_page && !split_hot) ? SCORE_BITS'(1) : trace_sum;
  assign fits      = raw_score <= SCORE_BITS'(BIN_COUNT - 1);

  // absent pages report nothing
  always_comb begin
    res.score     = page_present ? raw_score : '0;
    res.countable = page_present && fits;
    res.oor       = page_present && !fits;
    res.bin       = (page_present && fits) ? raw_score[BIN_BITS-1:0] : '0;
  end

endmodule

[tb/page_heat_checker.sv]
`timescale 1ns / 1ps

module page_heat_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [pgh_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [pgh_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  // page_present, split_page, split_hot, in_dram, access_codes[15:0], zero pad
  input  logic [pgh_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  input  logic                              s_axis_tlast,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // score[7:0], bin_index[4:0], counted, out_of_range, bin_count[31:0],
  // dram_total[31:0], nvm_total[31:0], zero pad
  input  logic [pgh_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input  logic                              m_axis_tlast,
  output int                                results_due,
  output int                                mismatches
);

  import pgh_pkg::*;

  typedef struct packed {
    logic [SCORE_BITS-1:0] score;
    logic [BIN_BITS-1:0]   bin_index;
    logic                  counted;
    logic                  out_of_range;
    logic [31:0]           bin_count;
    logic [31:0]           dram_total;
    logic [31:0]           nvm_total;
    logic                  last_page;
  } heat_result_t;

  // shadow of the weights and the histograms
  logic [WEIGHT_BITS-1:0] read_wt;
  logic [WEIGHT_BITS-1:0] write_wt;
  logic [COUNT_BITS-1:0]  dram_hist [BIN_COUNT];
  logic [COUNT_BITS-1:0]  nvm_hist  [BIN_COUNT];
  logic [COUNT_BITS-1:0]  dram_seen;
  logic [COUNT_BITS-1:0]  nvm_seen;
  heat_result_t           due_results [$];

  // saturating counter step
  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    heat_result_t            want;
    heat_result_t            got;
    logic [SCORE_BITS-1:0]   sum;
    logic [CODE_BITS-1:0]    codes;
    logic [1:0]              code;
    logic [IN_DATA_BITS-1:0] page;
    int                      k;
    if (rst) begin
      read_wt    = READ_WEIGHT_RST;
      write_wt   = WRITE_WEIGHT_RST;
      for (k = 0; k < BIN_COUNT; k++) begin
        dram_hist[k] = '0;
        nvm_hist[k]  = '0;
      end
      dram_seen = '0;
      nvm_seen  = '0;
      due_results.delete();
    end else begin
      // result word against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got.score        = m_axis_tdata[7:0];
        got.bin_index    = m_axis_tdata[12:8];
        got.counted      = m_axis_tdata[13];
        got.out_of_range = m_axis_tdata[14];
        got.bin_count    = m_axis_tdata[46:15];
        got.dram_total   = m_axis_tdata[78:47];
        got.nvm_total    = m_axis_tdata[110:79];
        got.last_page    = m_axis_tlast;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with nothing predicted: %p", $realtime, got);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch\n  want %p\n  got  %p", $realtime, want, got);
          end
        end
      end

      // predict the result of each page word taken
      if (s_axis_tvalid && s_axis_tready) begin
        page  = s_axis_tdata;
        codes = page[4 +: CODE_BITS];
        want  = '0;
        want.last_page = s_axis_tlast;
        if (page[0]) begin
          // cold split page scores one, others sum the trace
          if (page[1] && !page[2]) begin
            sum = SCORE_BITS'(1);
          end else begin
            sum = '0;
            for (k = 0; k < TRACE_SLOTS; k++) begin
              code = (2 * k < CODE_BITS) ? codes[2 * k +: 2] : 2'd0;
              if (code == CODE_READ)
                sum = sum + read_wt;
              else if (code == CODE_WRITE)
                sum = sum + write_wt;
            end
          end
          want.score = sum;
          if (sum <= BIN_COUNT - 1) begin
            want.bin_index = sum[BIN_BITS-1:0];
            want.counted   = 1'b1;
            if (page[3]) begin
              dram_hist[want.bin_index] = bump(dram_hist[want.bin_index]);
              want.bin_count = dram_hist[want.bin_index][31:0];
              dram_seen      = bump(dram_seen);
            end else begin
              nvm_hist[want.bin_index] = bump(nvm_hist[want.bin_index]);
              want.bin_count = nvm_hist[want.bin_index][31:0];
              nvm_seen       = bump(nvm_seen);
            end
          end else begin
            want.out_of_range = 1'b1;
          end
        end
        want.dram_total = dram_seen[31:0];
        want.nvm_total  = nvm_seen[31:0];
        due_results.push_back(want);
      end

      // weight writes
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_READ_WEIGHT:  read_wt  = cfg_wdata[WEIGHT_BITS-1:0];
          REG_WRITE_WEIGHT: write_wt = cfg_wdata[WEIGHT_BITS-1:0];
          default: ;
        endcase
      end
    end
    results_due <= due_results.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  import pgh_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 190;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_wr_en;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata;
  logic                     s_axis_tlast;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tlast;

  int results_due;
  int mismatches;
  int quiet_cycles = 0;
  bit steady = 1'b0;

  // read and write weights per phase, the last two drawn at random
  int read_tbl  [PHASES] = '{1, 0, 7, 0, 7, 5, 0, 0};
  int write_tbl [PHASES] = '{3, 0, 7, 7, 0, 6, 0, 0};

  always #5 clk = ~clk;

  page_heat_histogram uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  page_heat_checker heat_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .results_due   (results_due),
    .mismatches    (mismatches)
  );

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side with random stalls
  initial begin : sink
    int gap;
    m_axis_tready = 1'b0;
    forever begin
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // one page word with a random gap ahead of it
  task automatic send_page(input logic present, split, hot, dram,
                           input logic [CODE_BITS-1:0] codes, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, codes, dram, hot, split, present};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // random page, traces often limited to a few slots to stay in range
  task automatic send_random_page();
    logic [CODE_BITS-1:0] codes;
    codes = CODE_BITS'($urandom);
    case ($urandom_range(0, 3))
      1: codes = codes & 16'h00FF;
      2: codes = codes & 16'h0FFF;
      3: codes = codes & (16'hFFFF >> (2 * $urandom_range(1, 7)));
      default: ;
    endcase
    send_page($urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), codes,
              $urandom_range(0, 15) == 0);
  endtask

  // hold the sender until every predicted result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic set_weights(input logic [CFG_DATA_BITS-1:0] rd_w, wr_w);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_READ_WEIGHT;
    cfg_wdata <= rd_w;
    @(posedge clk);
    cfg_addr  <= REG_WRITE_WEIGHT;
    cfg_wdata <= wr_w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset weights: all reads, all writes, code three, empty trace
    send_page(1, 0, 0, 1, 16'h5555, 0);
    send_page(1, 0, 0, 0, 16'hAAAA, 0);
    send_page(1, 0, 0, 1, 16'hFFFF, 0);
    send_page(1, 0, 0, 0, 16'h0000, 0);
    // absent pages
    send_page(0, 0, 0, 1, 16'hAAAA, 1);
    send_page(0, 1, 1, 0, 16'hFFFF, 0);
    // split pages cold and hot
    send_page(1, 1, 0, 1, 16'hAAAA, 0);
    send_page(1, 1, 0, 0, 16'h0000, 0);
    send_page(1, 1, 1, 1, 16'h9966, 0);
    send_page(1, 0, 0, 1, 16'h1234, 1);
    send_page(1, 0, 0, 1, 16'h5555, 0);

    // last bin and one past it
    drain_results();
    set_weights(5, 6);
    send_page(1, 0, 0, 1, 16'h0555, 0);
    send_page(1, 0, 0, 0, 16'h0955, 0);
    send_page(1, 0, 0, 0, 16'h0555, 1);
    send_page(1, 0, 0, 1, 16'hAAAA, 0);
    send_page(1, 1, 0, 0, 16'hAAAA, 0);
    send_page(0, 0, 0, 0, 16'h0955, 0);

    // largest weights, then zero weights
    drain_results();
    set_weights(7, 7);
    send_page(1, 0, 0, 1, 16'hAAAA, 0);
    send_page(1, 1, 1, 0, 16'h5555, 0);
    send_page(1, 0, 0, 0, 16'h00AA, 1);
    drain_results();
    set_weights(0, 0);
    send_page(1, 0, 0, 1, 16'h5555, 0);
    send_page(1, 1, 0, 1, 16'hAAAA, 0);

    // random phases over several weight settings
    read_tbl[6]  = $urandom_range(0, 7);
    write_tbl[6] = $urandom_range(0, 7);
    read_tbl[7]  = $urandom_range(0, 7);
    write_tbl[7] = $urandom_range(0, 7);
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      set_weights(CFG_DATA_BITS'(read_tbl[phase]), CFG_DATA_BITS'(write_tbl[phase]));
      steady = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_random_page();
    end
    steady = 1'b0;

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && results_due == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
src/pgh_pkg.sv
src/pgh_score.sv
src/page_heat_histogram.sv
tb/page_heat_checker.sv
tb/testbench.sv
